FILE: sv/swc_pkg.sv
// Shared types, constants and SHA-256 helper functions for the work checker.
// Used by swc_round and sha256_work_check_core; no dependencies.
`timescale 1ns / 1ps

package swc_pkg;

  typedef logic [7:0][31:0]  swc_state_t;   // index 0 is working word a
  typedef logic [15:0][31:0] swc_window_t;  // index 0 is the word used this round

  // Values that travel beside the hash state through a round stage.
  typedef struct packed {
    logic [255:0] h;     // chaining value for the feed-forward add
    logic [15:0]  tail;  // last two nonce bytes, needed by the second block
  } swc_side_t;

  localparam int unsigned NumRounds = 64;
  localparam logic [2:0]  CfgDiff   = 3'd4;
  localparam logic [63:0] MsgBits   = 64'd528;
  localparam logic [7:0]  PadByte   = 8'h80;

  localparam logic [255:0] HInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] KRound = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Splits a 512-bit block, first byte in the top bits, into schedule words.
  function automatic swc_window_t to_window(input logic [511:0] blk);
    swc_window_t w;
    for (int j = 0; j < 16; j++) begin
      w[j] = blk[511 - 32*j -: 32];
    end
    to_window = w;
  endfunction

  // Turns eight 32-bit words, word 0 first, into a flat 256-bit value.
  function automatic logic [255:0] flatten(input swc_state_t s);
    logic [255:0] v;
    for (int j = 0; j < 8; j++) begin
      v[255 - 32*j -: 32] = s[j];
    end
    flatten = v;
  endfunction

  // Splits a flat 256-bit value, word 0 in the top bits, into eight words.
  function automatic swc_state_t unflatten(input logic [255:0] v);
    swc_state_t s;
    for (int j = 0; j < 8; j++) begin
      s[j] = v[255 - 32*j -: 32];
    end
    unflatten = s;
  endfunction

endpackage

FILE: sv/sha256_work_check_core.sv
// Top level of the SHA-256 proof-of-work checker: configuration registers,
// two unrolled 64-round pipelines and the scoring stage. Depends on swc_pkg.
`timescale 1ns / 1ps

// Usage:
// The configuration channel writes the 32 data bytes (indexes 0 to 3) and the
// 16-bit difficulty (index 4); other indexes are ignored. It is always ready
// and should only be written while no nonce is in flight.
// Each beat on the input channel carries one 32-byte nonce. The block hashes
// data, difficulty and nonce (two SHA-256 blocks) and returns one output beat
// with the work score and a flag that is set when the score exceeds the
// difficulty.
// Throughput is one nonce per cycle: each of the 128 rounds has its own
// register stage, so a new beat enters every cycle the pipe moves.
// From acceptance to the output beat, a nonce passes 64 rounds of the
// first block, one feed-forward stage, 64 rounds of the second block, one
// final add stage and the scoring stage, which is also the output register.
// The whole pipeline moves together. When the output holds a beat that the
// receiver does not take, every stage freezes and in_ready_o drops; nothing is
// lost or repeated. Empty stages carry cleared valid bits.
// Reset clears all valid bits and the configuration registers.
module sha256_work_check_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] nonce_bytes_0_7_i,
  input  logic [63:0] nonce_bytes_8_15_i,
  input  logic [63:0] nonce_bytes_16_23_i,
  input  logic [63:0] nonce_bytes_24_31_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] work_value_o,
  output logic        meets_target_o
);

  localparam int unsigned NR = swc_pkg::NumRounds;

  logic [3:0][63:0] data_q;
  logic [15:0]      diff_q;
  logic             en;

  // Stage arrays: entry j feeds round j, entry NR is the last round's output.
  logic                 b1_valid [NR+1];
  swc_pkg::swc_state_t  b1_st    [NR+1];
  swc_pkg::swc_window_t b1_w     [NR+1];
  swc_pkg::swc_side_t   b1_side  [NR+1];
  logic                 b2_valid [NR+1];
  swc_pkg::swc_state_t  b2_st    [NR+1];
  swc_pkg::swc_window_t b2_w     [NR+1];
  swc_pkg::swc_side_t   b2_side  [NR+1];

  logic                 mid_valid_q;
  swc_pkg::swc_state_t  mid_h_d, mid_h_q;
  swc_pkg::swc_window_t mid_w_q;
  logic                 fin_valid_q;
  logic [255:0]         fin_dig_d, fin_dig_q;
  logic [255:0]         nonce_all;

  assign cfg_ready_o = 1'b1;
  // The pipe advances unless a finished beat is stuck at the output.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
      diff_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i < swc_pkg::CfgDiff) begin
        data_q[2'd3 - cfg_index_i[1:0]] <= cfg_data_i;
      end else if (cfg_index_i == swc_pkg::CfgDiff) begin
        diff_q <= cfg_data_i[15:0];
      end
    end
  end

  // First block: data bytes, difficulty, then nonce bytes 0 to 29.
  assign nonce_all = {nonce_bytes_0_7_i, nonce_bytes_8_15_i,
                      nonce_bytes_16_23_i, nonce_bytes_24_31_i};
  assign b1_valid[0]     = in_valid_i;
  assign b1_st[0]        = swc_pkg::unflatten(swc_pkg::HInit);
  assign b1_w[0]         = swc_pkg::to_window({data_q, diff_q, nonce_all[255:16]});
  assign b1_side[0].h    = swc_pkg::HInit;
  assign b1_side[0].tail = nonce_all[15:0];

  for (genvar r = 0; r < NR; r++) begin : g_blk1
    swc_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (b1_valid[r]),
      .st_i    (b1_st[r]),
      .w_i     (b1_w[r]),
      .side_i  (b1_side[r]),
      .k_i     (swc_pkg::KRound[r]),
      .valid_o (b1_valid[r+1]),
      .st_o    (b1_st[r+1]),
      .w_o     (b1_w[r+1]),
      .side_o  (b1_side[r+1])
    );
  end

  // Feed-forward of the first block; the second block is built alongside:
  // the last two nonce bytes, the pad byte, zeros and the message length.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      mid_h_d[j] = b1_st[NR][j] + b1_side[NR].h[255 - 32*j -: 32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (en) begin
      mid_valid_q <= b1_valid[NR];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mid_h_q <= mid_h_d;
      mid_w_q <= swc_pkg::to_window({b1_side[NR].tail, swc_pkg::PadByte, 424'd0,
                                     swc_pkg::MsgBits});
    end
  end

  assign b2_valid[0]     = mid_valid_q;
  assign b2_st[0]        = mid_h_q;
  assign b2_w[0]         = mid_w_q;
  assign b2_side[0].h    = swc_pkg::flatten(mid_h_q);
  assign b2_side[0].tail = '0;

  for (genvar r = 0; r < NR; r++) begin : g_blk2
    swc_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (b2_valid[r]),
      .st_i    (b2_st[r]),
      .w_i     (b2_w[r]),
      .side_i  (b2_side[r]),
      .k_i     (swc_pkg::KRound[r]),
      .valid_o (b2_valid[r+1]),
      .st_o    (b2_st[r+1]),
      .w_o     (b2_w[r+1]),
      .side_o  (b2_side[r+1])
    );
  end

  // Final feed-forward gives the digest, first byte in the top bits.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      fin_dig_d[255 - 32*j -: 32] = b2_st[NR][j] + b2_side[NR].h[255 - 32*j -: 32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (en) begin
      fin_valid_q <= b2_valid[NR];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_dig_q <= fin_dig_d;
    end
  end

  swc_score u_score (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (fin_valid_q),
    .digest_i     (fin_dig_q),
    .difficulty_i (diff_q),
    .valid_o      (out_valid_o),
    .work_o       (work_value_o),
    .meets_o      (meets_target_o)
  );

  // The score can never pass 248 zero bits followed by a full byte.
  a_work_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (work_value_o <= 16'd63743))
    else $error("work value out of range");

  // A beat leaving the first block while the pipe moves passes the feed-forward register into the second block.
  a_mid_handoff : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && b1_valid[NR]) |=> b2_valid[0])
    else $error("beat lost between hash blocks");

  // A stalled output freezes the final stage.
  a_stall_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(fin_valid_q) && $stable(fin_dig_q))
    else $error("pipeline moved during a stall");

  // Input is taken exactly when the output stage can move.
  a_ready_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready disagrees with output stage");

endmodule

FILE: sv/swc_round.sv
// One registered SHA-256 round with its message schedule step.
// Depends on swc_pkg for the state, window and side types and round functions.
`timescale 1ns / 1ps

module swc_round (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  swc_pkg::swc_state_t  st_i,
  input  swc_pkg::swc_window_t w_i,
  input  swc_pkg::swc_side_t   side_i,
  input  logic [31:0]        k_i,
  output logic               valid_o,
  output swc_pkg::swc_state_t  st_o,
  output swc_pkg::swc_window_t w_o,
  output swc_pkg::swc_side_t   side_o
);

  logic                 valid_q;
  swc_pkg::swc_state_t  st_d, st_q;
  swc_pkg::swc_window_t w_d, w_q;
  swc_pkg::swc_side_t   side_q;
  logic [31:0]          t1, t2;

  always_comb begin
    t1 = st_i[7] + swc_pkg::big_sigma1(st_i[4])
       + ((st_i[4] & st_i[5]) ^ (~st_i[4] & st_i[6])) + k_i + w_i[0];
    t2 = swc_pkg::big_sigma0(st_i[0])
       + ((st_i[0] & st_i[1]) ^ (st_i[0] & st_i[2]) ^ (st_i[1] & st_i[2]));
    st_d[0] = t1 + t2;
    st_d[1] = st_i[0];
    st_d[2] = st_i[1];
    st_d[3] = st_i[2];
    st_d[4] = st_i[3] + t1;
    st_d[5] = st_i[4];
    st_d[6] = st_i[5];
    st_d[7] = st_i[6];
    w_d[14:0] = w_i[15:1];
    w_d[15] = w_i[0] + swc_pkg::small_sigma0(w_i[1]) + w_i[9]
            + swc_pkg::small_sigma1(w_i[14]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q   <= st_d;
      w_q    <= w_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign w_o     = w_q;
  assign side_o  = side_q;

endmodule

FILE: sv/swc_score.sv
// Digest scoring stage: leading zero count, following eight bits, target compare.
// Has no dependencies; holds the output register.
`timescale 1ns / 1ps

module swc_score (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [255:0] digest_i,
  input  logic [15:0]  difficulty_i,
  output logic         valid_o,
  output logic [15:0]  work_o,
  output logic         meets_o
);

  logic        valid_q;
  logic [15:0] work_d, work_q;
  logic        meets_q;
  logic [7:0]  zeros;
  logic [7:0]  low;
  logic [7:0]  cur;
  logic [15:0] pair;
  logic [2:0]  k;

  // The first nonzero byte among bytes 0 to 30 sets the score; scanning from
  // the back lets the earliest such byte win.
  always_comb begin
    zeros = 8'd248;
    low   = digest_i[7:0];
    k     = 3'd0;
    pair  = 16'd0;
    for (int i = 30; i >= 0; i--) begin
      cur = digest_i[255 - 8*i -: 8];
      if (cur != 8'd0) begin
        k = 3'd7;
        for (int b = 6; b >= 0; b--) begin
          if (cur[7 - b]) k = 3'(b);
        end
        pair  = {cur, digest_i[247 - 8*i -: 8]} << k;
        zeros = 8'(8*i) + {5'd0, k};
        low   = pair[15:8];
      end
    end
    work_d = {zeros, low};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q  <= work_d;
      meets_q <= work_d > difficulty_i;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;
  assign meets_o = meets_q;

endmodule
